FILE: rtl/playfair_pair_encrypt_core_macros.svh
// Assertion macros for the Playfair pair encryptor.
// Used by the top level only; no other dependencies.
`ifndef PLAYFAIR_PAIR_ENCRYPT_CORE_MACROS_SVH
`define PLAYFAIR_PAIR_ENCRYPT_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define PFE_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// next-cycle implication
`define PFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define PFE_ASSERT_IMPL(label, clk, rst, ante, cons)
`define PFE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/pfe_pkg.sv
// Shared types, constants and helpers for the Playfair pair encryptor.
// No dependencies.
`default_nettype none

package pfe_pkg;

  localparam int SQ_DIM   = 5;
  localparam int SQ_CELLS = 25;
  localparam int LETTERS  = 26;
  localparam int KEY_MAX  = 24;
  localparam int KEY_SLOTS = 24;   // letters held by the two key registers

  localparam logic [4:0] LETTER_I = 5'd8;
  localparam logic [4:0] LETTER_J = 5'd9;
  localparam logic [4:0] LETTER_X = 5'd23;

  // configuration register indexes
  localparam logic [1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [1:0] REG_KEY_LEN  = 2'd2;

  typedef enum logic [1:0] {
    BLD_KEY,
    BLD_FILL,
    BLD_DONE
  } build_state_t;

  // square build status and write command, builder -> top
  typedef struct packed {
    logic       busy;
    logic       wr_en;
    logic [4:0] sq_idx;
    logic [4:0] letter;
  } sq_build_t;

  // out-of-range codes read as X, J reads as I
  function automatic logic [4:0] clean_letter(input logic [4:0] raw);
    logic [4:0] v;
    v = raw;
    if (raw >= 5'(LETTERS)) v = LETTER_X;
    else if (raw == LETTER_J) v = LETTER_I;
    return v;
  endfunction

  function automatic logic [2:0] cell_row(input logic [4:0] sq_idx);
    logic [2:0] r;
    if (sq_idx >= 5'd20)      r = 3'd4;
    else if (sq_idx >= 5'd15) r = 3'd3;
    else if (sq_idx >= 5'd10) r = 3'd2;
    else if (sq_idx >= 5'd5)  r = 3'd1;
    else                      r = 3'd0;
    return r;
  endfunction

  function automatic logic [4:0] row_base(input logic [2:0] row);
    return {row, 2'b00} + {2'b00, row};
  endfunction

  function automatic logic [2:0] cell_col(input logic [4:0] sq_idx);
    logic [4:0] c;
    c = sq_idx - row_base(cell_row(sq_idx));
    return c[2:0];
  endfunction

  function automatic logic [2:0] wrap_inc(input logic [2:0] v);
    return (v == 3'(SQ_DIM - 1)) ? 3'd0 : v + 3'd1;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/pfe_square_builder.sv
// Key square sequencer: walks the key letters, then the alphabet, one step
// a cycle, and issues cell writes. Depends on pfe_pkg.
`default_nettype none

module pfe_square_builder import pfe_pkg::*; #(
  parameter int KEY_LIMIT = KEY_MAX
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [59:0] key_low,
  input  wire logic [59:0] key_high,
  input  wire logic [4:0]  key_len,
  output sq_build_t        bld
);

  build_state_t state, state_next;
  logic [4:0]   idx, idx_next;
  logic [4:0]   ch, ch_next;
  logic [4:0]   n, n_next;
  logic [LETTERS-1:0] used, used_next;

  logic [4:0] key_arr [KEY_SLOTS];
  logic [4:0] len_sat;
  logic [4:0] raw;
  logic [4:0] cand;
  logic       cand_ok;
  logic       wr_en;

  always_comb begin
    for (int i = 0; i < KEY_SLOTS / 2; i++) begin
      key_arr[i]                 = key_low[i*5 +: 5];
      key_arr[i + KEY_SLOTS / 2] = key_high[i*5 +: 5];
    end
  end

  assign len_sat = (key_len > 5'(KEY_LIMIT)) ? 5'(KEY_LIMIT) : key_len;

  always_ff @(posedge clk) begin
    if (rst || start) begin
      state <= BLD_KEY;
      idx   <= '0;
      ch    <= '0;
      n     <= '0;
      used  <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      ch    <= ch_next;
      n     <= n_next;
      used  <= used_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    ch_next    = ch;
    n_next     = n;
    used_next  = used;
    raw        = '0;
    cand       = '0;
    cand_ok    = 1'b0;
    unique case (state)
      BLD_KEY: begin
        if (idx >= len_sat) begin
          state_next = BLD_FILL;
        end else begin
          raw      = key_arr[idx];
          cand_ok  = (raw < 5'(LETTERS));
          cand     = (raw == LETTER_J) ? LETTER_I : raw;
          idx_next = idx + 5'd1;
        end
      end
      BLD_FILL: begin
        cand    = ch;
        cand_ok = (ch != LETTER_J);
        ch_next = ch + 5'd1;
        if (ch == 5'(LETTERS - 1)) state_next = BLD_DONE;
      end
      BLD_DONE: begin
      end
      default: state_next = BLD_DONE;
    endcase
    wr_en = cand_ok && !used[cand] && (n < 5'(SQ_CELLS));
    if (wr_en) begin
      used_next[cand] = 1'b1;
      n_next          = n + 5'd1;
    end
  end

  assign bld.busy   = (state != BLD_DONE);
  assign bld.wr_en  = wr_en;
  assign bld.sq_idx = n;
  assign bld.letter = cand;

endmodule

`default_nettype wire

FILE: rtl/playfair_pair_encrypt_core.sv
// Playfair pair encryptor, top level: config registers, square memories,
// two-stage lookup pipeline. Depends on pfe_pkg, pfe_square_builder, macros.
//
// Usage:
//  - cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): writes key_letters_low
//    (0), key_letters_high (1), key_length (2); other indexes are dropped.
//    cfg_ready is always high. Every write, and reset, starts a rebuild of
//    the key square; s_tready stays low until it is done.
//  - s channel: one plaintext pair per transfer. The accepted pair's valid
//    passes the v1 then the v2 register, and m_tvalid is v2; throughput one
//    pair per cycle while m_tready is high and no rebuild is running.
//  - Stage 1 registers the two letter-position reads, stage 2 the two
//    square reads into the output register.
//  - m channel: one cipher pair per input. When the receiver stalls, the
//    result holds in the output register and stage 1 still takes one more
//    pair; s_tready then drops until the output moves.
//  - rst (synchronous) clears the key registers and pipeline valids and
//    starts a rebuild giving the plain alphabetic square.
`default_nettype none
`include "playfair_pair_encrypt_core_macros.svh"

module playfair_pair_encrypt_core import pfe_pkg::*; #(
  parameter int KEY_LIMIT = KEY_MAX
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [59:0] cfg_data,
  // plaintext pair in
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [4:0] first_letter, [9:5] second_letter, rest 0
  input  wire logic        s_tuser,   // [0] lone_letter
  // cipher pair out
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0] m_tdata    // [4:0] first_cipher, [9:5] second_cipher, rest 0
);

  logic [59:0] key_low, key_high;
  logic [4:0]  key_len;
  logic        cfg_fire;
  sq_build_t   bld;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
      key_len  <= '0;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        REG_KEY_LOW:  key_low  <= cfg_data;
        REG_KEY_HIGH: key_high <= cfg_data;
        REG_KEY_LEN:  key_len  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // restart on any write transfer; a dropped index rebuilds the same square
  pfe_square_builder #(
    .KEY_LIMIT (KEY_LIMIT)
  ) u_builder (
    .clk      (clk),
    .rst      (rst),
    .start    (cfg_fire),
    .key_low  (key_low),
    .key_high (key_high),
    .key_len  (key_len),
    .bld      (bld)
  );

  // square memories: cell -> letter, letter -> cell (J entry never read)
  logic [4:0] sq_mem  [SQ_CELLS];
  logic [4:0] pos_mem [LETTERS];

  always_ff @(posedge clk) begin
    if (bld.wr_en) begin
      sq_mem[bld.sq_idx]  <= bld.letter;
      pos_mem[bld.letter] <= bld.sq_idx;
    end
  end

  // pipeline control
  logic v1, v2;
  logic en1, en2;
  logic s_fire;

  assign en2      = !v2 || m_tready;
  assign en1      = !v1 || en2;
  assign s_tready = en1 && !bld.busy;
  assign s_fire   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= s_fire;
      if (en2) v2 <= v1;
    end
  end

  // stage 0: letter cleanup, equal pair and lone letter take X
  logic [4:0] let_a, let_b, let_b_raw;

  assign let_a     = clean_letter(s_tdata[4:0]);
  assign let_b_raw = s_tuser ? LETTER_X : clean_letter(s_tdata[9:5]);
  assign let_b     = (let_a == let_b_raw) ? LETTER_X : let_b_raw;

  logic [4:0] pos_a, pos_b;

  always_ff @(posedge clk) begin
    if (s_fire) begin
      pos_a <= pos_mem[let_a];
      pos_b <= pos_mem[let_b];
    end
  end

  // stage 1: pick the cipher cells
  logic [2:0] r1, c1, r2, c2;
  logic [4:0] cell_a, cell_b;

  assign r1 = cell_row(pos_a);
  assign c1 = cell_col(pos_a);
  assign r2 = cell_row(pos_b);
  assign c2 = cell_col(pos_b);

  always_comb begin
    priority if (r1 == r2) begin
      cell_a = row_base(r1) + {2'b00, wrap_inc(c1)};
      cell_b = row_base(r2) + {2'b00, wrap_inc(c2)};
    end else if (c1 == c2) begin
      cell_a = row_base(wrap_inc(r1)) + {2'b00, c1};
      cell_b = row_base(wrap_inc(r2)) + {2'b00, c2};
    end else begin
      // rectangle: own row, partner's column
      cell_a = row_base(r1) + {2'b00, c2};
      cell_b = row_base(r2) + {2'b00, c1};
    end
  end

  // stage 2: square reads land in the output register
  logic [4:0] ciph_a, ciph_b;

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      ciph_a <= sq_mem[cell_a];
      ciph_b <= sq_mem[cell_b];
    end
  end

  assign m_tvalid = v2;
  assign m_tdata  = {6'b000000, ciph_b, ciph_a};

  // checks
  `PFE_ASSERT_NEXT(a_cfg_rebuild, clk, rst, cfg_fire, bld.busy)
  `PFE_ASSERT_NEXT(a_accept_fills_s1, clk, rst, s_fire, v1)
  `PFE_ASSERT_IMPL(a_cipher_range, clk, rst, m_tvalid,
                   (m_tdata[4:0] < 5'd26) && (m_tdata[9:5] < 5'd26))
  `PFE_ASSERT_IMPL(a_no_write_idle, clk, rst, !bld.busy, !bld.wr_en)

endmodule

`default_nettype wire

FILE: sim/tb_playfair_pair_encrypt_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for playfair_pair_encrypt_core: keyed squares, pair ciphering.
// Predicts each cipher pair from its own copy of the key square. Needs pfe_pkg and the core.

module tb_playfair_pair_encrypt_core import pfe_pkg::*; ();

  localparam logic [1:0] REG_NONE = 2'd3;   // unmapped index, write must be dropped
  localparam realtime RUN_LIMIT = 4ms;

  typedef struct packed {
    logic [4:0] first_cipher;
    logic [4:0] second_cipher;
  } cipher_pair_t;

  // receiver behavior, picked anew at random whenever the current run ends
  typedef enum int {RX_FREE, RX_PATTERN, RX_COIN, RX_CHOKE} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [59:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;    // [4:0] first_letter, [9:5] second_letter, rest 0
  logic        s_tuser = 1'b0;  // [0] lone_letter
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;         // [4:0] first_cipher, [9:5] second_cipher, rest 0

  // local copy of the key registers and the square they build
  logic [59:0] key_lo_q = '0;
  logic [59:0] key_hi_q = '0;
  logic [4:0]  key_len_q = '0;
  logic [4:0]  square_letter [SQ_CELLS];
  logic [4:0]  letter_cell [LETTERS];

  cipher_pair_t pending_ciphers [$];
  cipher_pair_t want_pair;
  int error_count = 0;
  int tx_burst_left = 0;

  rx_mode_t   rx_mode = RX_FREE;
  int         rx_left = 0;
  logic [7:0] rx_mask = 8'h01;

  playfair_pair_encrypt_core dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  initial begin
    #(RUN_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Square prediction
  // ---------------------------------------------------------------------------

  // J folds into I, codes past Z read as X
  function automatic logic [4:0] canon_letter(input logic [4:0] raw);
    if (raw >= LETTERS) return LETTER_X;
    if (raw == LETTER_J) return LETTER_I;
    return raw;
  endfunction

  // key letters first (dups, bad codes skipped), then the rest of A..Z minus J
  function automatic void rebuild_square();
    logic taken [LETTERS];
    int n;
    int len;
    logic [4:0] v;
    n = 0;
    len = (key_len_q > KEY_MAX) ? KEY_MAX : int'(key_len_q);
    foreach (taken[c]) taken[c] = 1'b0;
    for (int i = 0; i < len; i++) begin
      v = (i < 12) ? key_lo_q[5*i +: 5] : key_hi_q[5*(i-12) +: 5];
      if (v < LETTERS) begin
        if (v == LETTER_J) v = LETTER_I;
        if (!taken[v] && n < SQ_CELLS) begin
          square_letter[n] = v;
          taken[v] = 1'b1;
          n++;
        end
      end
    end
    for (int c = 0; c < LETTERS; c++) begin
      if (c != LETTER_J && !taken[c] && n < SQ_CELLS) begin
        square_letter[n] = 5'(c);
        taken[c] = 1'b1;
        n++;
      end
    end
    for (int p = 0; p < SQ_CELLS; p++) letter_cell[square_letter[p]] = 5'(p);
    letter_cell[LETTER_J] = letter_cell[LETTER_I];
  endfunction

  function automatic cipher_pair_t encipher_pair(input logic [4:0] first_raw,
                                                 input logic [4:0] second_raw,
                                                 input logic lone);
    logic [4:0] a, b;
    int ra, ca, rb, cb;
    cipher_pair_t r;
    a = canon_letter(first_raw);
    b = lone ? LETTER_X : canon_letter(second_raw);
    if (a == b) b = LETTER_X;
    ra = letter_cell[a] / SQ_DIM;
    ca = letter_cell[a] % SQ_DIM;
    rb = letter_cell[b] / SQ_DIM;
    cb = letter_cell[b] % SQ_DIM;
    if (ra == rb) begin
      // same row (also X,X in one cell): right neighbor, wrapping
      r.first_cipher  = square_letter[ra*SQ_DIM + (ca + 1) % SQ_DIM];
      r.second_cipher = square_letter[rb*SQ_DIM + (cb + 1) % SQ_DIM];
    end else if (ca == cb) begin
      r.first_cipher  = square_letter[((ra + 1) % SQ_DIM)*SQ_DIM + ca];
      r.second_cipher = square_letter[((rb + 1) % SQ_DIM)*SQ_DIM + cb];
    end else begin
      // rectangle: own row, partner's column
      r.first_cipher  = square_letter[ra*SQ_DIM + cb];
      r.second_cipher = square_letter[rb*SQ_DIM + ca];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: stall pattern and result check
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 160);
      rx_mask = 8'($urandom) | 8'h01;
    end
    rx_left--;
    case (rx_mode)
      RX_FREE: m_tready <= 1'b1;
      RX_PATTERN: begin
        m_tready <= rx_mask[0];
        rx_mask = {rx_mask[0], rx_mask[7:1]};
      end
      RX_COIN: m_tready <= ($urandom_range(0, 3) != 0);
      default: m_tready <= ($urandom_range(0, 9) == 0);   // heavy backpressure
    endcase
  end

  // every transfer on m is matched against the oldest predicted pair
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_ciphers.size() == 0) begin
        $error("unexpected cipher pair, m_tdata %h", m_tdata);
        error_count++;
      end else begin
        want_pair = pending_ciphers.pop_front();
        if (m_tdata[4:0] !== want_pair.first_cipher) begin
          $error("first_cipher: expected %0d, got %0d", want_pair.first_cipher, m_tdata[4:0]);
          error_count++;
        end
        if (m_tdata[9:5] !== want_pair.second_cipher) begin
          $error("second_cipher: expected %0d, got %0d", want_pair.second_cipher,
                 m_tdata[9:5]);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  function automatic logic [4:0] letter(input byte c);
    return 5'(c - 8'h41);   // 'A' -> 0
  endfunction

  function automatic logic [119:0] key_from_text(input string s);
    logic [119:0] k;
    k = '0;
    for (int i = 0; i < s.len() && i < 24; i++) k[5*i +: 5] = letter(s[i]);
    return k;
  endfunction

  // mostly real letters, now and then an out-of-range code
  function automatic logic [4:0] random_letter();
    if ($urandom_range(0, 9) == 0) return 5'($urandom_range(26, 31));
    return 5'($urandom_range(0, 25));
  endfunction

  // one pair transfer; bursts of random length separated by random gaps
  task automatic send_pair(input logic [4:0] first_letter, input logic [4:0] second_letter,
                           input logic lone);
    int gap;
    if (tx_burst_left == 0) begin
      tx_burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    tx_burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, second_letter, first_letter};
    s_tuser  <= lone;
    do @(posedge clk); while (!s_tready);
    pending_ciphers.push_back(encipher_pair(first_letter, second_letter, lone));
  endtask

  // leaves cfg_valid high so back-to-back writes need no extra NBA
  task automatic cfg_write(input logic [1:0] idx, input logic [59:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_KEY_LOW:  key_lo_q = data;
      REG_KEY_HIGH: key_hi_q = data;
      REG_KEY_LEN:  key_len_q = data[4:0];
      default: ;
    endcase
    rebuild_square();
  endtask

  // stop sending and let every predicted pair come out
  task automatic wait_for_ciphers();
    int spins;
    spins = 0;
    s_tvalid <= 1'b0;
    while (pending_ciphers.size() != 0 && spins < 20000) begin
      @(posedge clk);
      spins++;
    end
    if (pending_ciphers.size() != 0) begin
      $error("%0d cipher pairs never arrived", pending_ciphers.size());
      error_count++;
      pending_ciphers.delete();
    end
  endtask

  // new key while the core is idle; the stray write hits the unmapped index
  task automatic load_key(input logic [119:0] key, input logic [59:0] len_word,
                          input bit stray);
    wait_for_ciphers();
    cfg_write(REG_KEY_LOW, key[59:0]);
    cfg_write(REG_KEY_HIGH, key[119:60]);
    cfg_write(REG_KEY_LEN, len_word);
    if (stray) cfg_write(REG_NONE, 60'({$urandom, $urandom}));
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset square is plain A..Z without J
  task automatic test_plain_square();
    send_pair(letter("A"), letter("B"), 1'b0);   // same row
    send_pair(letter("E"), letter("A"), 1'b0);   // row wrap
    send_pair(letter("A"), letter("F"), 1'b0);   // same column
    send_pair(letter("V"), letter("A"), 1'b0);   // column wrap
    send_pair(letter("A"), letter("G"), 1'b0);   // rectangle
    send_pair(letter("A"), letter("A"), 1'b0);   // doubled letter
    send_pair(letter("J"), letter("I"), 1'b0);   // doubled after J folding
    send_pair(letter("J"), letter("K"), 1'b0);
    send_pair(letter("X"), letter("X"), 1'b0);   // both in one cell
    send_pair(letter("X"), 5'd31, 1'b1);         // lone X
    send_pair(letter("A"), letter("Z"), 1'b1);   // lone letter, second ignored
    send_pair(5'd31, 5'd26, 1'b0);               // codes past Z
    send_pair(letter("Z"), letter("Y"), 1'b0);
  endtask

  task automatic test_keyed_squares();
    // repeated key letters and a J in the key
    load_key(key_from_text("PLAYFAIRJEXAMPLE"), 60'd16, 1'b0);
    send_pair(letter("H"), letter("I"), 1'b0);
    send_pair(letter("D"), letter("E"), 1'b0);
    send_pair(letter("J"), letter("X"), 1'b0);
    // all 24 slots used, length word all ones (saturates), then an unmapped write
    load_key(key_from_text("ZYXWVUTSRQPONMLKIHGFEDCB"), {60{1'b1}}, 1'b1);
    send_pair(letter("A"), letter("Z"), 1'b0);
    send_pair(letter("B"), letter("C"), 1'b1);
    // every key code out of range: plain square again
    load_key({120{1'b1}}, 60'd24, 1'b0);
    send_pair(letter("A"), letter("B"), 1'b0);
    send_pair(letter("Q"), letter("Z"), 1'b0);
    // key present but zero length
    load_key(key_from_text("QQQQQQQQQQQQQQQQQQQQQQQQ"), 60'd0, 1'b0);
    send_pair(letter("A"), letter("Z"), 1'b0);
  endtask

  task automatic test_random_traffic();
    logic [119:0] key;
    logic [59:0] len_word;
    logic [4:0] a;
    for (int phase = 0; phase < 8; phase++) begin
      if (phase % 2 == 0) begin
        key = 120'({$urandom, $urandom, $urandom, $urandom});   // raw codes, some bad
      end else begin
        for (int i = 0; i < 24; i++) key[5*i +: 5] = 5'($urandom_range(0, 25));
      end
      len_word = 60'({$urandom, $urandom});
      case (phase)
        0: len_word[4:0] = 5'd0;
        1: len_word[4:0] = 5'(KEY_MAX);
        2: len_word[4:0] = 5'd31;
        default: len_word[4:0] = 5'($urandom_range(0, 31));
      endcase
      load_key(key, len_word, phase % 3 == 0);
      repeat (56) begin
        a = random_letter();
        case ($urandom_range(0, 9))
          0: send_pair(a, a, 1'b0);
          1: send_pair(a, 5'($urandom), 1'b1);
          default: send_pair(a, random_letter(), 1'b0);
        endcase
      end
    end
  endtask

  initial begin
    rebuild_square();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_plain_square();
    test_keyed_squares();
    test_random_traffic();
    wait_for_ciphers();
    repeat (8) @(posedge clk);   // catch any pair the core emits late
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
